// File: rtl/core/scqc_pkg.sv
// scqc_pkg: constants, types and helper functions for the sample clamp,
// quantize and color map block. No dependencies.
`default_nettype none

package scqc_pkg;

    // configuration register indexes (8-byte spacing on the bus)
    localparam int unsigned ADDR_W = 5;
    localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_INV_RANGE  = 2'd2;

    localparam logic signed [31:0] LOW_LIMIT_RST  = 32'sd0;
    localparam logic signed [31:0] HIGH_LIMIT_RST = 32'sd65536;
    localparam logic [47:0]        INV_RANGE_RST  = 48'h0001_0000_0000;

    localparam int unsigned NUM_CH = 3;

    // knots in hundredths, entry 0 is the low end of the map
    typedef logic [5:0] t_knot;
    typedef t_knot [4:0] t_knot_tab;

    localparam t_knot_tab RED_KNOTS   = {6'd45, 6'd23, 6'd2,  6'd3,  6'd2};
    localparam t_knot_tab GREEN_KNOTS = {6'd2,  6'd23, 6'd45, 6'd23, 6'd2};
    localparam t_knot_tab BLUE_KNOTS  = {6'd2,  6'd3,  6'd2,  6'd23, 6'd45};

    // ceil(2^17 / 25), exact quotient for dividends below 2^12
    localparam logic [12:0] RECIP_25 = 13'd5243;

    // p[i]*16384 + v*(p[i+1]-p[i]), always in [0, 45*16384]
    function automatic logic [19:0] f_knot_num(input t_knot_tab tab,
                                               input logic [1:0] seg,
                                               input logic [13:0] v);
        logic [2:0]         seg_nx;
        t_knot              k_lo;
        t_knot              k_hi;
        logic signed [6:0]  slope;
        logic signed [21:0] prod;
        logic signed [21:0] sum;
        seg_nx = {1'b0, seg} + 3'd1;
        k_lo   = tab[seg];
        k_hi   = tab[seg_nx];
        slope  = signed'({1'b0, k_hi}) - signed'({1'b0, k_lo});
        prod   = 22'(signed'({1'b0, v}) * slope);
        sum    = signed'({2'b00, k_lo, 14'b0}) + prod;
        return sum[19:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sample_clamp_quantize_colormap.sv
// sample_clamp_quantize_colormap: six-stage pipeline from a Q16.16 sample to
// 8/12-bit levels and an interpolated RGB color. Uses scqc_pkg.
// stages: 6, a word accepted at the input passes through each stage register in turn
// throughput: one word per cycle; each stage holds or takes a word on its own,
// so bubbles close up under a stall and input is taken while any stage is free
// reset: synchronous active-low, clears stage valid bits and restores config defaults
`default_nettype none

module sample_clamp_quantize_colormap
    import scqc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [63:0]              pwdata,
    output logic      [63:0]              prdata,
    output logic                          pready,

    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [31:0]       i_sample,

    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [7:0]               o_level8,
    output logic      [11:0]              o_level12,
    output logic      [7:0]               o_red,
    output logic      [7:0]               o_green,
    output logic      [7:0]               o_blue
);

    localparam int unsigned STAGES = 6;
    localparam t_knot_tab KNOTS [NUM_CH] = '{RED_KNOTS, GREEN_KNOTS, BLUE_KNOTS};

    // configuration
    logic signed [31:0] r_low_limit;
    logic signed [31:0] r_high_limit;
    logic [47:0]        r_inv_range;
    logic [1:0]         cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
            r_inv_range  <= INV_RANGE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOW_LIMIT:  r_low_limit  <= signed'(pwdata[31:0]);
                REG_HIGH_LIMIT: r_high_limit <= signed'(pwdata[31:0]);
                REG_INV_RANGE:  r_inv_range  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOW_LIMIT:  prdata = {32'd0, r_low_limit};
            REG_HIGH_LIMIT: prdata = {32'd0, r_high_limit};
            REG_INV_RANGE:  prdata = {16'd0, r_inv_range};
            default:        prdata = 64'd0;
        endcase
    end

    // per-stage flow control: a stage loads when empty or when the next one moves
    logic [STAGES:1] r_vld;
    logic [STAGES:1] en;

    always_comb begin
        en[STAGES] = !r_vld[STAGES] || !i_stall;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: clamp and offset from the low limit
    logic signed [31:0] clamp_lo;
    logic signed [31:0] clamped;
    logic signed [32:0] offs;
    logic [31:0]        n1_diff;
    logic [31:0]        r1_diff;

    always_comb begin
        clamp_lo = (i_sample < r_low_limit) ? r_low_limit : i_sample;
        clamped  = (clamp_lo > r_high_limit) ? r_high_limit : clamp_lo;
        offs     = 33'(clamped) - 33'(r_low_limit);
        // inverted limits land at or below low_limit and give zero
        n1_diff  = (clamped <= r_low_limit) ? 32'd0 : offs[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_diff <= n1_diff;
        end
    end

    // stage 2: split scale multiply, high 16 bits and low 32 bits of inv_range
    logic [47:0] n2_phi;
    logic [63:0] plo_full;
    logic [47:0] r2_phi;
    logic [31:0] r2_plo;

    assign n2_phi   = r1_diff * r_inv_range[47:32];
    assign plo_full = r1_diff * r_inv_range[31:0];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_phi <= n2_phi;
            r2_plo <= plo_full[63:32];
        end
    end

    // stage 3: combine and saturate to a 16-bit fraction
    logic [48:0] q_sum;
    logic [15:0] n3_t;
    logic [15:0] r3_t;

    assign q_sum = {1'b0, r2_phi} + {17'd0, r2_plo};
    assign n3_t  = (|q_sum[48:16]) ? 16'hFFFF : q_sum[15:0];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_t <= n3_t;
        end
    end

    // stage 4: segment interpolation numerator per channel
    logic [19:0] n4_num [NUM_CH];
    logic [19:0] r4_num [NUM_CH];
    logic [11:0] r4_lvl;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n4_num[c] = f_knot_num(KNOTS[c], r3_t[15:14], r3_t[13:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_num <= n4_num;
            r4_lvl <= r3_t[15:4];
        end
    end

    // stage 5: 255*num / 2^16, the power-of-two part of the divisor
    logic [27:0] scaled [NUM_CH];
    logic [11:0] n5_w   [NUM_CH];
    logic [11:0] r5_w   [NUM_CH];
    logic [11:0] r5_lvl;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            scaled[c] = {r4_num[c], 8'd0} - {8'd0, r4_num[c]};
            n5_w[c]   = scaled[c][27:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_w   <= n5_w;
            r5_lvl <= r4_lvl;
        end
    end

    // stage 6: divide by 25 through the reciprocal
    logic [24:0] recip_prod [NUM_CH];
    logic [7:0]  n6_ch      [NUM_CH];
    logic [7:0]  r6_ch      [NUM_CH];
    logic [11:0] r6_lvl;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            recip_prod[c] = r5_w[c] * RECIP_25;
            n6_ch[c]      = recip_prod[c][24:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_ch  <= n6_ch;
            r6_lvl <= r5_lvl;
        end
    end

    assign o_level12 = r6_lvl;
    assign o_level8  = r6_lvl[11:4];
    assign o_red     = r6_ch[0];
    assign o_green   = r6_ch[1];
    assign o_blue    = r6_ch[2];

endmodule

`default_nettype wire
